[design/ipmd_pkg.sv]
package ipmd_pkg;

  localparam int unsigned MAC_BYTES_DEF = 14;
  localparam int unsigned IP_HDR_BYTES  = 20;
  localparam int unsigned TDATA_W       = 16;

  localparam logic [1:0] KIND_INNER   = 2'd0;
  localparam logic [1:0] KIND_PASS    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] VERD_SPLIT  = 2'd0;
  localparam logic [1:0] VERD_ACCEPT = 2'd1;
  localparam logic [1:0] VERD_DROP   = 2'd2;

  // what one accepted item has to put out before its optional verdict
  localparam logic [1:0] PLAN_NONE   = 2'd0;
  localparam logic [1:0] PLAN_FLUSH  = 2'd1;
  localparam logic [1:0] PLAN_PREFIX = 2'd2;
  localparam logic [1:0] PLAN_BYTE   = 2'd3;

  typedef struct packed {
    logic step;
    logic rd;
    logic ld_mem;
    logic ld_inner;
    logic ld_byte;
    logic ld_verd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] plan_d;
    logic       verd_d;
    logic [1:0] plan_q;
    logic       verd_q;
    logic       mem_last;
    logic       inner_last;
    logic       slot_free;
  } sts_t;

endpackage

[design/ipmd_ctrl.sv]
module ipmd_ctrl #(
  parameter int unsigned MAC_BYTES = ipmd_pkg::MAC_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ipmd_pkg::sts_t  sts_i,
  output ipmd_pkg::cmd_t  cmd_o
);
  import ipmd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MEM   = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_BYTE  = 3'd4;
  localparam logic [2:0] S_VERD  = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          unique case (sts_i.plan_d)
            PLAN_FLUSH:  state_d = S_RD;
            PLAN_PREFIX: state_d = (MAC_BYTES > 0) ? S_RD : S_INNER;
            PLAN_BYTE:   state_d = S_BYTE;
            default:     state_d = sts_i.verd_d ? S_VERD : S_IDLE;
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MEM;
      end
      S_MEM: begin
        if (sts_i.slot_free) begin
          cmd_o.ld_mem = 1'b1;
          if (!sts_i.mem_last) begin
            state_d = S_RD;
          end else if (sts_i.plan_q == PLAN_PREFIX) begin
            state_d = S_INNER;
          end else begin
            state_d = sts_i.verd_q ? S_VERD : S_IDLE;
          end
        end
      end
      S_INNER: begin
        if (sts_i.slot_free) begin
          cmd_o.ld_inner = 1'b1;
          if (sts_i.inner_last) begin
            state_d = sts_i.verd_q ? S_VERD : S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (sts_i.slot_free) begin
          cmd_o.ld_byte = 1'b1;
          state_d = sts_i.verd_q ? S_VERD : S_IDLE;
        end
      end
      S_VERD: begin
        if (sts_i.slot_free) begin
          cmd_o.ld_verd = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/ipmd_dp.sv]
module ipmd_dp #(
  parameter int unsigned MAC_BYTES = ipmd_pkg::MAC_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic [7:0]                    byte_i,
  input  logic                          last_i,
  input  ipmd_pkg::cmd_t                cmd_i,
  output ipmd_pkg::sts_t                sts_o,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [ipmd_pkg::TDATA_W-1:0]  m_data_o,
  output logic [1:0]                    m_user_o,
  output logic                          m_last_o
);
  import ipmd_pkg::*;

  localparam int unsigned HOLD     = MAC_BYTES + 10;
  localparam int unsigned PROTO    = MAC_BYTES + 9;
  localparam int unsigned HW       = $clog2(HOLD);
  localparam int unsigned CW       = $clog2(HOLD + 1);
  localparam int unsigned IDXW     = $clog2(MAC_BYTES + IP_HDR_BYTES + 1);
  localparam int unsigned PAD      = TDATA_W - 12;

  localparam logic CFG_META   = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  localparam logic [2:0] PH_HEADER     = 3'd0;
  localparam logic [2:0] PH_PASS       = 3'd1;
  localparam logic [2:0] PH_OUTER      = 3'd2;
  localparam logic [2:0] PH_INNER_HEAD = 3'd3;
  localparam logic [2:0] PH_INNER_BODY = 3'd4;
  localparam logic [2:0] PH_TRAIL      = 3'd5;
  localparam logic [2:0] PH_DISCARD    = 3'd6;

  logic [7:0]      meta_q;
  logic [15:0]     maxlen_q;

  logic [2:0]      phase_q, phase_d;
  logic [IDXW-1:0] idx_q, idx_d, idx_inc;
  logic [15:0]     orem_q, orem_d;
  logic [15:0]     ileft_q, ileft_d, ileft_dec;
  logic [7:0]      olen_hi_q, olen_lo_q;
  logic [15:0]     olen, ilen;

  logic [7:0]      hold_mem [HOLD];
  logic [7:0]      rdata_q;
  logic [7:0]      ihold_q [4];

  logic [1:0]      plan_q, plan_d;
  logic [CW-1:0]   lim_q, lim_d;
  logic            fend_q, fend_d;
  logic [1:0]      bkind_q, bkind_d;
  logic            bend_q, bend_d;
  logic [7:0]      bdata_q;
  logic            verd_q;
  logic [1:0]      verdict_q, verdict_d;

  logic [CW-1:0]   cnt_q;
  logic [1:0]      icnt_q;
  logic            mem_last;

  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [7:0]      out_data_q;
  logic            out_start_q, out_end_q, out_last_q;
  logic [1:0]      out_verd_q;
  logic            ld_any;

  assign olen      = {olen_hi_q, olen_lo_q};
  assign ilen      = {ihold_q[2], byte_i};
  assign idx_inc   = idx_q + 1'b1;
  assign ileft_dec = ileft_q - 16'(ileft_q != 16'd0);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    orem_d    = orem_q;
    ileft_d   = ileft_q;
    plan_d    = PLAN_NONE;
    lim_d     = CW'(MAC_BYTES);
    fend_d    = 1'b0;
    bkind_d   = KIND_INNER;
    bend_d    = 1'b0;
    verdict_d = VERD_DROP;
    unique case (phase_q)
      PH_HEADER: begin
        idx_d = idx_inc;
        if (idx_q == IDXW'(PROTO)) begin
          if (byte_i != meta_q) begin
            plan_d  = PLAN_FLUSH;
            lim_d   = CW'(HOLD);
            fend_d  = last_i;
            phase_d = PH_PASS;
          end else begin
            phase_d = PH_OUTER;
          end
        end else if (last_i) begin
          plan_d = PLAN_FLUSH;
          lim_d  = CW'(idx_inc);
          fend_d = 1'b1;
        end
      end
      PH_PASS: begin
        plan_d  = PLAN_BYTE;
        bkind_d = KIND_PASS;
        bend_d  = last_i;
      end
      PH_OUTER: begin
        idx_d = idx_inc;
        if (idx_q == IDXW'(MAC_BYTES + IP_HDR_BYTES - 1)) begin
          idx_d = '0;
          if (olen < 16'(IP_HDR_BYTES)) begin
            phase_d = PH_DISCARD;
          end else begin
            orem_d  = olen - 16'(IP_HDR_BYTES);
            phase_d = (orem_d != 16'd0) ? PH_INNER_HEAD : PH_TRAIL;
          end
        end
      end
      PH_INNER_HEAD: begin
        idx_d = idx_inc;
        if (idx_q == IDXW'(3)) begin
          idx_d = '0;
          if (ilen < 16'(IP_HDR_BYTES) || ilen > orem_q || ilen > maxlen_q) begin
            phase_d = PH_DISCARD;
          end else begin
            plan_d  = PLAN_PREFIX;
            ileft_d = ilen - 16'd4;
            orem_d  = orem_q - ilen;
            phase_d = PH_INNER_BODY;
          end
        end
      end
      PH_INNER_BODY: begin
        ileft_d = ileft_dec;
        plan_d  = PLAN_BYTE;
        bkind_d = KIND_INNER;
        bend_d  = (ileft_dec == 16'd0);
        if (ileft_dec == 16'd0) begin
          phase_d = (orem_q != 16'd0) ? PH_INNER_HEAD : PH_TRAIL;
        end
      end
      default: ;
    endcase
    if (last_i) begin
      priority if (phase_d == PH_PASS || phase_d == PH_HEADER) begin
        verdict_d = VERD_ACCEPT;
      end else if (phase_d == PH_TRAIL) begin
        verdict_d = VERD_SPLIT;
      end else begin
        verdict_d = VERD_DROP;
      end
      phase_d = PH_HEADER;
      idx_d   = '0;
      orem_d  = '0;
      ileft_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q   <= 8'd253;
      maxlen_q <= 16'd1500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_META:   meta_q   <= cfg_wdata_i[7:0];
        CFG_MAXLEN: maxlen_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= '0;
      orem_q  <= '0;
      ileft_q <= '0;
      plan_q  <= PLAN_NONE;
      verd_q  <= 1'b0;
      cnt_q   <= '0;
      icnt_q  <= '0;
    end else begin
      if (cmd_i.step) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        orem_q  <= orem_d;
        ileft_q <= ileft_d;
        plan_q  <= plan_d;
        verd_q  <= last_i;
        cnt_q   <= '0;
        icnt_q  <= '0;
      end
      if (cmd_i.ld_mem) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.ld_inner) begin
        icnt_q <= icnt_q + 1'b1;
      end
    end
  end

  // item plan and held bytes: payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      lim_q     <= lim_d;
      fend_q    <= fend_d;
      bkind_q   <= bkind_d;
      bend_q    <= bend_d;
      bdata_q   <= byte_i;
      verdict_q <= verdict_d;
      if (phase_q == PH_HEADER && idx_q == IDXW'(MAC_BYTES + 2)) begin
        olen_hi_q <= byte_i;
      end
      if (phase_q == PH_HEADER && idx_q == IDXW'(MAC_BYTES + 3)) begin
        olen_lo_q <= byte_i;
      end
      if (phase_q == PH_INNER_HEAD) begin
        ihold_q[idx_q[1:0]] <= byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && phase_q == PH_HEADER) begin
      hold_mem[idx_q[HW-1:0]] <= byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= hold_mem[cnt_q[HW-1:0]];
    end
  end

  assign mem_last = ((cnt_q + 1'b1) == lim_q);
  assign ld_any   = cmd_i.ld_mem | cmd_i.ld_inner | cmd_i.ld_byte | cmd_i.ld_verd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_any) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.ld_mem) begin
      out_kind_q  <= (plan_q == PLAN_FLUSH) ? KIND_PASS : KIND_INNER;
      out_data_q  <= rdata_q;
      out_start_q <= (cnt_q == '0);
      out_end_q   <= (plan_q == PLAN_FLUSH) && fend_q && mem_last;
      out_verd_q  <= VERD_SPLIT;
      out_last_q  <= (plan_q == PLAN_FLUSH) && mem_last && !verd_q;
    end else if (cmd_i.ld_inner) begin
      out_kind_q  <= KIND_INNER;
      out_data_q  <= ihold_q[icnt_q];
      out_start_q <= (MAC_BYTES == 0) && (icnt_q == 2'd0);
      out_end_q   <= 1'b0;
      out_verd_q  <= VERD_SPLIT;
      out_last_q  <= (icnt_q == 2'd3) && !verd_q;
    end else if (cmd_i.ld_byte) begin
      out_kind_q  <= bkind_q;
      out_data_q  <= bdata_q;
      out_start_q <= 1'b0;
      out_end_q   <= bend_q;
      out_verd_q  <= VERD_SPLIT;
      out_last_q  <= !verd_q;
    end else if (cmd_i.ld_verd) begin
      out_kind_q  <= KIND_VERDICT;
      out_data_q  <= 8'd0;
      out_start_q <= 1'b0;
      out_end_q   <= 1'b0;
      out_verd_q  <= verdict_q;
      out_last_q  <= 1'b1;
    end else begin
      out_kind_q  <= out_kind_q;
    end
  end

  assign sts_o.plan_d     = plan_d;
  assign sts_o.verd_d     = last_i;
  assign sts_o.plan_q     = plan_q;
  assign sts_o.verd_q     = verd_q;
  assign sts_o.mem_last   = mem_last;
  assign sts_o.inner_last = (icnt_q == 2'd3);
  assign sts_o.slot_free  = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {{PAD{1'b0}}, out_verd_q, out_end_q, out_start_q, out_data_q};
  assign m_user_o  = out_kind_q;
  assign m_last_o  = out_last_q;

endmodule

[design/ip_meta_packet_deaggregator.sv]
// Splits frames whose outer IP protocol equals meta_protocol into their inner
// IP packets, each re-prefixed with the frame's MAC header; other frames pass
// through, and every frame ends with one verdict item (split, accept, drop).
// Each input byte is accepted only in the idle state; a byte that yields
// an output byte then passes through the byte-load state, and frame end
// adds the verdict-load state. A header flush or inner packet start
// replays held header bytes from a single-port buffer with registered read,
// a read state and a load state per byte, then the four inner header bytes.
// Output stalls hold the input off. No clearing pass after reset.
module ip_meta_packet_deaggregator #(
  parameter int unsigned MAC_BYTES = ipmd_pkg::MAC_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] frame_byte
  input  logic                          s_axis_tlast_i,  // frame_end
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_data, [8] packet_start, [9] packet_end, [11:10] verdict
  output logic [ipmd_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic [1:0]                    m_axis_tuser_o,  // [1:0] out_kind
  output logic                          m_axis_tlast_o   // run_last
);
  import ipmd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipmd_ctrl #(
    .MAC_BYTES (MAC_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipmd_dp #(
    .MAC_BYTES (MAC_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_data_o    (m_axis_tdata_o),
    .m_user_o    (m_axis_tuser_o),
    .m_last_o    (m_axis_tlast_o)
  );

`ifndef ASSERT_OFF
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ld_mem, cmd.ld_inner, cmd.ld_byte, cmd.ld_verd}))
    else $error("more than one output load");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ld_mem || cmd.ld_inner || cmd.ld_byte || cmd.ld_verd) |-> sts.slot_free)
    else $error("output register overwritten");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_VERDICT) |-> m_axis_tlast_o)
    else $error("verdict item not marked last");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !(cmd.rd || cmd.ld_mem || cmd.ld_inner || cmd.ld_byte || cmd.ld_verd))
    else $error("item accepted during output sequence");
`endif

endmodule
